/* hw/rtl/piecewise_linear_calibration_lookup_assert.svh */
// Assertion macros for the calibration lookup block.
// Depends on nothing; expands to nothing when SYNTH is defined.
`ifndef PIECEWISE_LINEAR_CALIBRATION_LOOKUP_ASSERT_SVH
`define PIECEWISE_LINEAR_CALIBRATION_LOOKUP_ASSERT_SVH

`ifndef SYNTH
`define PLC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define PLC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define PLC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define PLC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

/* hw/rtl/plc_pkg.sv */
// Shared constants, codes and types of the calibration lookup block.
// Used by every module in hw/rtl; depends on nothing.
package plc_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int FREQ_BITS   = 20;
  localparam int IDX_BITS    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int AMP_BITS    = 16;
  localparam int PCNT_BITS   = 7;
  localparam int CIDX_BITS   = 2;
  localparam int DVD_BITS    = FREQ_BITS + AMP_BITS;
  localparam int DCNT_BITS   = $clog2(DVD_BITS + 1);

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  localparam logic [CIDX_BITS-1:0] CFG_MIN_AMP    = 2'd0;
  localparam logic [CIDX_BITS-1:0] CFG_MAX_AMP    = 2'd1;
  localparam logic [CIDX_BITS-1:0] CFG_POINT_CNT  = 2'd2;

  typedef enum logic [2:0] {
    PATH_OFF    = 3'd0,
    PATH_BELOW  = 3'd1,
    PATH_ABOVE  = 3'd2,
    PATH_INTERP = 3'd3,
    PATH_DEGEN  = 3'd4
  } path_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_SCAN,
    S_MUL,
    S_DIVS,
    S_DIV,
    S_FIN,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [FREQ_BITS-1:0] freq;
    logic [AMP_BITS-1:0]  amp;
  } entry_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* hw/rtl/plc_table.sv */
// Calibration table memory: one write port, one registered read port.
// Depends on plc_pkg for depth and entry type.
module plc_table (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [plc_pkg::IDX_BITS-1:0]  wr_addr_i,
  input  plc_pkg::entry_t               wr_data_i,
  input  logic [plc_pkg::IDX_BITS-1:0]  rd_addr_i,
  output plc_pkg::entry_t               rd_data_o
);

  plc_pkg::entry_t mem_q [plc_pkg::TABLE_DEPTH];
  plc_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hw/rtl/plc_div.sv */
// Serial restoring divider, one quotient bit per cycle.
// Depends on plc_pkg for operand widths and the status struct.
module plc_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [plc_pkg::DVD_BITS-1:0]    dividend_i,
  input  logic [plc_pkg::FREQ_BITS-1:0]   divisor_i,
  output logic [plc_pkg::DVD_BITS-1:0]    quot_o,
  output logic [plc_pkg::FREQ_BITS-1:0]   rem_o,
  output plc_pkg::div_stat_t              stat_o
);

  localparam int DB = plc_pkg::DVD_BITS;
  localparam int FB = plc_pkg::FREQ_BITS;
  localparam int CB = plc_pkg::DCNT_BITS;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CB-1:0] cnt_q, cnt_d;
  logic [DB-1:0] dvd_q, dvd_d;
  logic [FB-1:0] rem_q, rem_d;
  logic [FB-1:0] dsr_q, dsr_d;
  logic [FB:0]   shifted;
  logic          ge;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    shifted = {rem_q, dvd_q[DB-1]};
    ge      = shifted >= {1'b0, dsr_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DB-2:0], ge};
      rem_d = ge ? FB'(shifted - {1'b0, dsr_q}) : shifted[FB-1:0];
      cnt_d = cnt_q + CB'(1);
      if (cnt_q == CB'(DB - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign quot_o      = dvd_q;
  assign rem_o       = rem_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

/* hw/rtl/piecewise_linear_calibration_lookup.sv */
// Sequence: a write is taken on transfer; a lookup with a zero target goes straight to output,
// one out of range after the first and last entries are read, a degenerate bracket after the
// scan and an interpolated one after the scan, multiply and serial divide. One item at a time;
// the scan (one entry per cycle through the single memory read port) and divider set lookup time.
// Reset: control and configuration take their reset values; the table is not cleared.
// Depends on plc_pkg, plc_table, plc_div and the assertion macro header.
`include "piecewise_linear_calibration_lookup_assert.svh"

module piecewise_linear_calibration_lookup (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [plc_pkg::CIDX_BITS-1:0]   cfg_index_i,
  input  logic [15:0]                     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            req_type_i,
  input  logic [5:0]                      entry_index_i,
  input  logic [plc_pkg::FREQ_BITS-1:0]   entry_frequency_i,
  input  logic [plc_pkg::AMP_BITS-1:0]    entry_amplitude_i,
  input  logic [plc_pkg::FREQ_BITS-1:0]   target_frequency_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [plc_pkg::AMP_BITS-1:0]    amplitude_o,
  output logic [2:0]                      path_o
);

  localparam int FB = plc_pkg::FREQ_BITS;
  localparam int AB = plc_pkg::AMP_BITS;
  localparam int IB = plc_pkg::IDX_BITS;
  localparam int DB = plc_pkg::DVD_BITS;

  plc_pkg::state_e state_q, state_d;

  logic [AB-1:0]                  min_amp_q, max_amp_q;
  logic [plc_pkg::PCNT_BITS-1:0]  pcnt_q;
  logic [IB-1:0]                  n_last;

  logic [FB-1:0]       t_q, t_d;
  plc_pkg::entry_t     first_q, first_d;
  plc_pkg::entry_t     prev_q, prev_d;
  plc_pkg::entry_t     lo_q, lo_d;
  plc_pkg::entry_t     hi_q, hi_d;
  logic [IB-1:0]       idx_q, idx_d;
  logic [DB-1:0]       mag_q, mag_d;
  logic                neg_q, neg_d;
  logic [AB-1:0]       res_amp_q, res_amp_d;
  plc_pkg::path_e      res_path_q, res_path_d;
  logic                out_valid_q, out_valid_d;
  logic [AB-1:0]       out_amp_q, out_amp_d;
  plc_pkg::path_e      out_path_q, out_path_d;

  logic                in_fire, wr_en;
  logic [IB-1:0]       rd_addr;
  plc_pkg::entry_t     rd_data, wr_data;
  logic                div_start;
  logic [DB-1:0]       div_quot;
  logic [FB-1:0]       div_rem;
  plc_pkg::div_stat_t  div_stat;

  logic [FB-1:0]        dt, df;
  logic [AB-1:0]        da_mag;
  logic [AB:0]          q_mag;
  logic signed [AB+1:0] v;
  logic [AB-1:0]        v_sat, v_clamp;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != plc_pkg::S_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign wr_en       = in_fire && (req_type_i == plc_pkg::REQ_WRITE)
                       && (32'(entry_index_i) < plc_pkg::TABLE_DEPTH);
  assign wr_data     = '{freq: entry_frequency_i, amp: entry_amplitude_i};

  always_comb begin
    if (pcnt_q < plc_pkg::PCNT_BITS'(2)) begin
      n_last = IB'(1);
    end else if (32'(pcnt_q) > plc_pkg::TABLE_DEPTH) begin
      n_last = IB'(plc_pkg::TABLE_DEPTH - 1);
    end else begin
      n_last = IB'(32'(pcnt_q) - 32'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_amp_q <= '0;
      max_amp_q <= '1;
      pcnt_q    <= plc_pkg::PCNT_BITS'(64);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        plc_pkg::CFG_MIN_AMP:   min_amp_q <= cfg_data_i;
        plc_pkg::CFG_MAX_AMP:   max_amp_q <= cfg_data_i;
        plc_pkg::CFG_POINT_CNT: pcnt_q    <= cfg_data_i[plc_pkg::PCNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  plc_table u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (IB'(entry_index_i)),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  plc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag_q),
    .divisor_i  (df),
    .quot_o     (div_quot),
    .rem_o      (div_rem),
    .stat_o     (div_stat)
  );

  assign dt     = t_q - lo_q.freq;
  assign df     = hi_q.freq - lo_q.freq;
  assign da_mag = (hi_q.amp < lo_q.amp) ? (lo_q.amp - hi_q.amp) : (hi_q.amp - lo_q.amp);
  assign q_mag  = {1'b0, div_quot[AB-1:0]} + (AB+1)'(div_rem != '0 && neg_q);
  assign v      = neg_q ? ((AB+2)'(lo_q.amp) - (AB+2)'(q_mag))
                        : ((AB+2)'(lo_q.amp) + (AB+2)'(q_mag));

  always_comb begin
    priority if (v < 0) begin
      v_sat = '0;
    end else if (v > (AB+2)'(2**AB - 1)) begin
      v_sat = '1;
    end else begin
      v_sat = v[AB-1:0];
    end
    v_clamp = (v_sat > max_amp_q) ? max_amp_q : v_sat;
    v_clamp = (v_clamp < min_amp_q) ? min_amp_q : v_clamp;
  end

  always_comb begin
    state_d     = state_q;
    t_d         = t_q;
    first_d     = first_q;
    prev_d      = prev_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    idx_d       = idx_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    res_amp_d   = res_amp_q;
    res_path_d  = res_path_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_amp_d   = out_amp_q;
    out_path_d  = out_path_q;
    rd_addr     = '0;
    div_start   = 1'b0;
    unique case (state_q)
      plc_pkg::S_IDLE: begin
        if (in_fire && req_type_i == plc_pkg::REQ_LOOKUP) begin
          t_d = target_frequency_i;
          if (target_frequency_i == '0) begin
            res_amp_d  = '0;
            res_path_d = plc_pkg::PATH_OFF;
            state_d    = plc_pkg::S_OUT;
          end else begin
            state_d = plc_pkg::S_FIRST;
          end
        end
      end
      plc_pkg::S_FIRST: begin
        first_d = rd_data;
        rd_addr = n_last;
        state_d = plc_pkg::S_LAST;
      end
      plc_pkg::S_LAST: begin
        rd_addr = IB'(1);
        idx_d   = IB'(1);
        prev_d  = first_q;
        priority if (t_q < first_q.freq) begin
          res_amp_d  = first_q.amp;
          res_path_d = plc_pkg::PATH_BELOW;
          state_d    = plc_pkg::S_OUT;
        end else if (t_q > rd_data.freq) begin
          res_amp_d  = rd_data.amp;
          res_path_d = plc_pkg::PATH_ABOVE;
          state_d    = plc_pkg::S_OUT;
        end else begin
          state_d = plc_pkg::S_SCAN;
        end
      end
      plc_pkg::S_SCAN: begin
        rd_addr = idx_q + IB'(1);
        priority if (prev_q.freq <= t_q && rd_data.freq >= t_q) begin
          lo_d = prev_q;
          hi_d = rd_data;
          if (rd_data.freq == prev_q.freq) begin
            res_amp_d  = prev_q.amp;
            res_path_d = plc_pkg::PATH_DEGEN;
            state_d    = plc_pkg::S_OUT;
          end else begin
            state_d = plc_pkg::S_MUL;
          end
        end else if (idx_q == n_last) begin
          res_amp_d  = first_q.amp;
          res_path_d = plc_pkg::PATH_DEGEN;
          state_d    = plc_pkg::S_OUT;
        end else begin
          prev_d = rd_data;
          idx_d  = idx_q + IB'(1);
        end
      end
      plc_pkg::S_MUL: begin
        mag_d   = DB'(dt) * DB'(da_mag);
        neg_d   = hi_q.amp < lo_q.amp;
        state_d = plc_pkg::S_DIVS;
      end
      plc_pkg::S_DIVS: begin
        div_start = 1'b1;
        state_d   = plc_pkg::S_DIV;
      end
      plc_pkg::S_DIV: begin
        if (div_stat.done) begin
          state_d = plc_pkg::S_FIN;
        end
      end
      plc_pkg::S_FIN: begin
        res_amp_d  = v_clamp;
        res_path_d = plc_pkg::PATH_INTERP;
        state_d    = plc_pkg::S_OUT;
      end
      plc_pkg::S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_amp_d   = res_amp_q;
          out_path_d  = res_path_q;
          state_d     = plc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = plc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= plc_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q        <= t_d;
    first_q    <= first_d;
    prev_q     <= prev_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    idx_q      <= idx_d;
    mag_q      <= mag_d;
    neg_q      <= neg_d;
    res_amp_q  <= res_amp_d;
    res_path_q <= res_path_d;
    out_amp_q  <= out_amp_d;
    out_path_q <= out_path_d;
  end

  assign out_valid_o = out_valid_q;
  assign amplitude_o = out_amp_q;
  assign path_o      = out_path_q;

  `PLC_ASSERT_NXT(a_lookup_leaves_idle, clk_i, rst_ni, in_fire && req_type_i == plc_pkg::REQ_LOOKUP, state_q != plc_pkg::S_IDLE, "lookup transfer did not start the sequencer")
  `PLC_ASSERT_IMP(a_div_only_in_div, clk_i, rst_ni, div_stat.busy, state_q == plc_pkg::S_DIV, "divider busy outside divide state")
  `PLC_ASSERT_IMP(a_scan_in_range, clk_i, rst_ni, state_q == plc_pkg::S_SCAN, idx_q <= n_last && idx_q != '0, "scan index outside active table")
  `PLC_ASSERT_IMP(a_interp_clamped, clk_i, rst_ni, out_valid_q && out_path_q == plc_pkg::PATH_INTERP && min_amp_q <= max_amp_q, out_amp_q >= min_amp_q && out_amp_q <= max_amp_q, "interpolated amplitude outside bounds")

endmodule

/* tb/tb_top.sv */
// Testbench for the piecewise-linear calibration lookup: loads tables, sweeps clamp and
// point-count settings, and checks every lookup result against a scoreboard predictor.
// Depends on plc_pkg and the piecewise_linear_calibration_lookup RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam logic [plc_pkg::CIDX_BITS-1:0] CFG_SPARE = 2'd3;

  typedef enum int {
    TBL_SCRAMBLED,
    TBL_RISING,
    TBL_FLAT_START
  } table_kind_e;

  typedef struct packed {
    logic [plc_pkg::AMP_BITS-1:0] amp;
    plc_pkg::path_e               path;
  } lookup_result_t;

  class lookup_scoreboard;
    logic [plc_pkg::FREQ_BITS-1:0] freq_tab [plc_pkg::TABLE_DEPTH];
    logic [plc_pkg::AMP_BITS-1:0]  amp_tab  [plc_pkg::TABLE_DEPTH];
    logic [plc_pkg::AMP_BITS-1:0]  amp_lo;
    logic [plc_pkg::AMP_BITS-1:0]  amp_hi;
    logic [plc_pkg::PCNT_BITS-1:0] point_cnt;
    lookup_result_t                awaited [$];
    int                            mismatches;

    function new();
      amp_lo = '0;
      amp_hi = '1;
      point_cnt = 7'd64;
      mismatches = 0;
      foreach (freq_tab[i]) begin
        freq_tab[i] = '0;
        amp_tab[i] = '0;
      end
    endfunction

    function int active_points();
      if (point_cnt < 2) return 2;
      if (point_cnt > plc_pkg::TABLE_DEPTH) return plc_pkg::TABLE_DEPTH;
      return int'(point_cnt);
    endfunction

    function void set_reg(logic [plc_pkg::CIDX_BITS-1:0] idx, logic [15:0] data);
      case (idx)
        plc_pkg::CFG_MIN_AMP: amp_lo = data;
        plc_pkg::CFG_MAX_AMP: amp_hi = data;
        plc_pkg::CFG_POINT_CNT: point_cnt = data[plc_pkg::PCNT_BITS-1:0];
        default: ;
      endcase
    endfunction

    function lookup_result_t map_target(logic [plc_pkg::FREQ_BITS-1:0] t);
      lookup_result_t r;
      int n, lo, hi, i;
      bit found;
      longint dt, df, da, prod, q, v;
      n = active_points();
      lo = 0;
      hi = 0;
      found = 1'b0;
      if (t == 0) begin
        r.amp = '0;
        r.path = plc_pkg::PATH_OFF;
      end else if (t < freq_tab[0]) begin
        r.amp = amp_tab[0];
        r.path = plc_pkg::PATH_BELOW;
      end else if (t > freq_tab[n-1]) begin
        r.amp = amp_tab[n-1];
        r.path = plc_pkg::PATH_ABOVE;
      end else begin
        for (i = 0; i + 1 < n && !found; i++) begin
          if (freq_tab[i] <= t && freq_tab[i+1] >= t) begin
            lo = i;
            hi = i + 1;
            found = 1'b1;
          end
        end
        if (!found || freq_tab[hi] == freq_tab[lo]) begin
          r.amp = amp_tab[lo];
          r.path = plc_pkg::PATH_DEGEN;
        end else begin
          dt = longint'(t) - longint'(freq_tab[lo]);
          df = longint'(freq_tab[hi]) - longint'(freq_tab[lo]);
          da = longint'(amp_tab[hi]) - longint'(amp_tab[lo]);
          prod = dt * da;
          if (prod >= 0) q = prod / df;
          else q = -((-prod + df - 1) / df);
          v = longint'(amp_tab[lo]) + q;
          if (v > longint'(amp_hi)) v = longint'(amp_hi);
          if (v < longint'(amp_lo)) v = longint'(amp_lo);
          r.amp = v[plc_pkg::AMP_BITS-1:0];
          r.path = plc_pkg::PATH_INTERP;
        end
      end
      return r;
    endfunction

    function void note_item(logic rt, logic [5:0] idx, logic [plc_pkg::FREQ_BITS-1:0] ef,
                            logic [plc_pkg::AMP_BITS-1:0] ea,
                            logic [plc_pkg::FREQ_BITS-1:0] tf);
      if (rt == plc_pkg::REQ_WRITE) begin
        if (idx < plc_pkg::TABLE_DEPTH) begin
          freq_tab[idx] = ef;
          amp_tab[idx] = ea;
        end
      end else begin
        awaited.push_back(map_target(tf));
      end
    endfunction

    function void check_result(logic [plc_pkg::AMP_BITS-1:0] amp, logic [2:0] path);
      lookup_result_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: lookup result with none pending: amp %h path %0d", $time, amp, path);
      end else begin
        want = awaited.pop_front();
        if (amp !== want.amp || path !== want.path) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: lookup mismatch: expected amp %h path %0d, got amp %h path %0d",
                     $time, want.amp, want.path, amp, path);
        end
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [plc_pkg::CIDX_BITS-1:0]  cfg_index = '0;
  logic [15:0]                    cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           req_type = plc_pkg::REQ_WRITE;
  logic [5:0]                     entry_index = '0;
  logic [plc_pkg::FREQ_BITS-1:0]  entry_freq = '0;
  logic [plc_pkg::AMP_BITS-1:0]   entry_amp = '0;
  logic [plc_pkg::FREQ_BITS-1:0]  target_freq = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [plc_pkg::AMP_BITS-1:0]   amplitude;
  logic [2:0]                     path;
  bit                             in_idle_on = 1'b1;
  bit                             out_idle_on = 1'b1;
  lookup_scoreboard               sb;

  piecewise_linear_calibration_lookup dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .req_type_i         (req_type),
    .entry_index_i      (entry_index),
    .entry_frequency_i  (entry_freq),
    .entry_amplitude_i  (entry_amp),
    .target_frequency_i (target_freq),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .amplitude_o        (amplitude),
    .path_o             (path)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall)
        sb.note_item(req_type, entry_index, entry_freq, entry_amp, target_freq);
      if (out_valid && !out_stall) sb.check_result(amplitude, path);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (out_idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input logic rt, input logic [5:0] idx,
                           input logic [plc_pkg::FREQ_BITS-1:0] ef,
                           input logic [plc_pkg::AMP_BITS-1:0] ea,
                           input logic [plc_pkg::FREQ_BITS-1:0] tf);
    if (in_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    entry_index <= idx;
    entry_freq <= ef;
    entry_amp <= ea;
    target_freq <= tf;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_write(input logic [5:0] idx, input logic [plc_pkg::FREQ_BITS-1:0] f,
                            input logic [plc_pkg::AMP_BITS-1:0] a);
    send_item(plc_pkg::REQ_WRITE, idx, f, a, plc_pkg::FREQ_BITS'($urandom));
  endtask

  task automatic send_lookup(input logic [plc_pkg::FREQ_BITS-1:0] t);
    send_item(plc_pkg::REQ_LOOKUP, 6'($urandom), plc_pkg::FREQ_BITS'($urandom),
              plc_pkg::AMP_BITS'($urandom), t);
  endtask

  task automatic write_reg(input logic [plc_pkg::CIDX_BITS-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic load_table(input table_kind_e kind, input int n);
    logic [plc_pkg::FREQ_BITS-1:0] f;
    int step_max, i;
    step_max = $urandom_range(16, 16000);
    f = plc_pkg::FREQ_BITS'($urandom_range(1, 4000));
    for (i = 0; i < n; i++) begin
      if (kind == TBL_SCRAMBLED) begin
        f = plc_pkg::FREQ_BITS'($urandom_range(0, 20'hFFFFF));
      end else if (i > 0 && !(kind == TBL_FLAT_START && (i == 1 || $urandom_range(0, 5) == 0)))
      begin
        f = f + plc_pkg::FREQ_BITS'($urandom_range(1, step_max));
      end
      send_write(6'(i), f, plc_pkg::AMP_BITS'($urandom));
    end
  endtask

  function automatic logic [plc_pkg::FREQ_BITS-1:0] pick_target(input int n);
    logic [plc_pkg::FREQ_BITS-1:0] f0, fl;
    int k;
    f0 = sb.freq_tab[0];
    fl = sb.freq_tab[n-1];
    k = $urandom_range(0, n - 2);
    case ($urandom_range(0, 11))
      0: return (f0 > 1) ? plc_pkg::FREQ_BITS'($urandom_range(f0 - 1, 1)) : '0;
      1: return (fl < 20'hFFFFF) ? plc_pkg::FREQ_BITS'($urandom_range(20'hFFFFF, fl + 1)) : fl;
      2: return plc_pkg::FREQ_BITS'($urandom);
      3: return '0;
      4, 5: return sb.freq_tab[k];
      default: return plc_pkg::FREQ_BITS'($urandom_range(sb.freq_tab[k+1], sb.freq_tab[k]));
    endcase
  endfunction

  task automatic run_mix(input int count);
    logic [plc_pkg::FREQ_BITS-1:0] lo_f, hi_f;
    int n, k;
    repeat (count) begin
      n = sb.active_points();
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 4) == 0) begin
          send_write(6'($urandom_range(0, plc_pkg::TABLE_DEPTH - 1)),
                     plc_pkg::FREQ_BITS'($urandom), plc_pkg::AMP_BITS'($urandom));
        end else begin
          k = $urandom_range(0, n - 1);
          lo_f = (k == 0) ? '0 : sb.freq_tab[k-1];
          hi_f = (k == plc_pkg::TABLE_DEPTH - 1) ? 20'hFFFFF : sb.freq_tab[k+1];
          send_write(6'(k), plc_pkg::FREQ_BITS'($urandom_range(hi_f, lo_f)),
                     plc_pkg::AMP_BITS'($urandom));
        end
      end else begin
        send_lookup(pick_target(n));
      end
    end
  endtask

  initial begin
    logic [plc_pkg::FREQ_BITS-1:0] probes [11];
    logic [plc_pkg::FREQ_BITS-1:0] f;
    logic [plc_pkg::AMP_BITS-1:0]  a;
    logic [15:0]                   lo_v, hi_v, pc_word;
    logic [6:0]                    pc;
    int                            i, ph, n_pts;
    probes = '{20'd0, 20'd1, 20'd15, 20'd16, 20'd17, 20'd16017, 20'd32016,
               20'd500000, 20'd992016, 20'd992017, 20'hFFFFF};
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < plc_pkg::TABLE_DEPTH; i++) begin
      f = (i < 2) ? plc_pkg::FREQ_BITS'(16) : plc_pkg::FREQ_BITS'(16 + (i - 1) * 16000);
      a = (i < 4) ? ((i % 2 == 0) ? 16'hFFFF : 16'h0000) : plc_pkg::AMP_BITS'($urandom);
      send_write(6'(i), f, a);
    end
    foreach (probes[j]) send_lookup(probes[j]);
    send_write(6'd63, 20'hFFFFF, 16'h1234);
    send_lookup(20'hFFFFF);
    send_lookup(20'hFFFFE);

    for (ph = 1; ph <= 9; ph++) begin
      settle();
      in_idle_on = (ph != 5 && ph != 9);
      out_idle_on = (ph != 6 && ph != 9);
      case (ph)
        1: begin lo_v = 16'h1000; hi_v = 16'h8000; pc = 7'd64;  end
        2: begin lo_v = 16'h9000; hi_v = 16'h2000; pc = 7'd2;   end
        3: begin lo_v = 16'h0000; hi_v = 16'hFFFF; pc = 7'd0;   end
        4: begin lo_v = 16'hFFFF; hi_v = 16'h0000; pc = 7'd1;   end
        5: begin lo_v = 16'h0000; hi_v = 16'hFFFF; pc = 7'd127; end
        default: begin
          lo_v = 16'($urandom_range(0, 16'h7FFF));
          hi_v = 16'($urandom_range(16'hFFFF, 16'h8000));
          pc = 7'($urandom_range(2, plc_pkg::TABLE_DEPTH));
        end
      endcase
      n_pts = (pc < 7'd2) ? 2
            : ((int'(pc) > plc_pkg::TABLE_DEPTH) ? plc_pkg::TABLE_DEPTH : int'(pc));
      pc_word = 16'($urandom);
      pc_word[6:0] = pc;
      write_reg(plc_pkg::CFG_MIN_AMP, lo_v);
      write_reg(plc_pkg::CFG_MAX_AMP, hi_v);
      write_reg(plc_pkg::CFG_POINT_CNT, pc_word);
      if (ph == 3) write_reg(CFG_SPARE, 16'($urandom));
      cfg_valid <= 1'b0;
      load_table(table_kind_e'(ph % 3), n_pts);
      run_mix(10);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #1_200_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/plc_pkg.sv
hw/rtl/plc_table.sv
hw/rtl/plc_div.sv
hw/rtl/piecewise_linear_calibration_lookup.sv
tb/tb_top.sv
